[src/ebd_pkg.sv]
// ----------------------------------------------------------------------------
// ebd_pkg
// Shared types and constants of the edge-timed barcode decoder.
// ----------------------------------------------------------------------------
package ebd_pkg;

   localparam int unsigned CODE_BITS = 8;
   localparam int unsigned END_COUNT = 2 * CODE_BITS + 2;
   localparam int unsigned CNT_W     = $clog2(END_COUNT + 1);
   localparam int unsigned DIV_W     = 32;
   localparam int unsigned DCNT_W    = $clog2(DIV_W);

   // operation codes carried on req_tuser
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_POLL = 1'b1;

   // register indexes
   localparam logic CSR_BIT_LENGTH = 1'b0;
   localparam logic CSR_TIMEOUT    = 1'b1;

   // result status codes
   localparam logic [2:0] ST_NO_CODE     = 3'd0;
   localparam logic [2:0] ST_IN_PROGRESS = 3'd1;
   localparam logic [2:0] ST_SUCCESS     = 3'd2;
   localparam logic [2:0] ST_PHASE_ERROR = 3'd3;
   localparam logic [2:0] ST_TIMEOUT     = 3'd4;

   typedef struct packed {
      logic edge_go;    // edge transfer accepted
      logic poll_go;    // poll transfer accepted
      logic div_step;   // advance divider one quotient bit
      logic load_div;   // move divider result to output register
   } ebd_cmd_type;

   typedef struct packed {
      logic div_needed; // current poll is a success with nonzero period
      logic div_last;   // divider on its final step
   } ebd_sts_type;

endpackage

[src/edge_timed_barcode_decoder_core.sv]
// ----------------------------------------------------------------------------
// edge_timed_barcode_decoder_core
// Decodes an 8-bit barcode from timestamped sensor edges; polls report status.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transfer carries
//  -------  ---------  ---------------------------------------------------
//  req_     in         tuser: operation; tdata: pin_level, time_us
//  rsp_     out        tuser: status; tdata: code_value, velocity
//  csr_     in         register write (0 bit_length_scaled, 1 reading_timeout)
//
//  An edge, or a poll that reports anything but a success with a nonzero bit
//  period, is done once it is taken; such a success runs the 32-step bit-serial
//  divider and then loads its result (accept, divide steps, load).
//  A new transfer is taken only when idle and the result register is empty or
//  its result leaves in the same cycle; a stalled result side holds edges too.
//  Reset is synchronous, active high, and clears decoder and register state.
//
module edge_timed_barcode_decoder_core (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] operation
   input  logic [39:0] req_tdata,   // [0] pin_level, [32:1] time_us, [39:33] zero
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic [39:0] rsp_tdata,   // [7:0] code_value, [39:8] velocity
   // register writes
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);
   import ebd_pkg::*;

   ebd_cmd_type cmd;   // controller -> datapath
   ebd_sts_type sts;   // datapath -> controller

   logic [7:0]  code_value;
   logic [31:0] velocity;

   // sequencing: accept, divide, deliver
   ebd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // edge timing, poll evaluation, divider and result register
   ebd_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .req_pin      (req_tdata[0]),
      .req_time     (req_tdata[32:1]),
      .rsp_status   (rsp_tuser),
      .rsp_code     (code_value),
      .rsp_velocity (velocity)
   );

   assign rsp_tdata = {velocity, code_value};

   // no new transfer while the divider runs
   a_no_accept_in_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_tready)
      else $error("request accepted during divide");

   // last divide step always hands over to delivery
   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && sts.div_last) |=> !cmd.div_step)
      else $error("divider ran past its last step");

   // a poll without division shows its result on the next cycle
   a_quick_poll: assert property (@(posedge clock) disable iff (reset)
      (cmd.poll_go && !sts.div_needed) |=> rsp_tvalid)
      else $error("poll result missing");

endmodule

[src/ebd_ctrl.sv]
// ----------------------------------------------------------------------------
// ebd_ctrl
// Sequencer: handshakes, divide sequencing and result valid.
// ----------------------------------------------------------------------------
module ebd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output ebd_pkg::ebd_cmd_type cmd,
   input  ebd_pkg::ebd_sts_type sts
);
   import ebd_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_DIVIDE, S_DELIVER} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      req_tready   = (state_ff == S_IDLE) && out_free;
      accept       = req_tvalid && req_tready;
      cmd.edge_go  = accept && (req_tuser == OP_EDGE);
      cmd.poll_go  = accept && (req_tuser == OP_POLL);
      cmd.div_step = (state_ff == S_DIVIDE);
      cmd.load_div = (state_ff == S_DELIVER) && out_free;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.poll_go) begin
               if (sts.div_needed) begin
                  state_in = S_DIVIDE;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_DIVIDE: begin
            if (sts.div_last) begin
               state_in = S_DELIVER;
            end
         end
         S_DELIVER: begin
            if (cmd.load_div) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[src/ebd_datapath.sv]
// ----------------------------------------------------------------------------
// ebd_datapath
// Edge timing state, poll evaluation, bit-serial divider, result register.
// ----------------------------------------------------------------------------
module ebd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ebd_pkg::ebd_cmd_type cmd,
   output ebd_pkg::ebd_sts_type sts,
   input  logic                 csr_we,
   input  logic                 csr_addr,
   input  logic [31:0]          csr_wdata,
   input  logic                 req_pin,
   input  logic [31:0]          req_time,
   output logic [2:0]           rsp_status,
   output logic [7:0]           rsp_code,
   output logic [31:0]          rsp_velocity
);
   import ebd_pkg::*;

   // configuration
   logic [31:0]          bls_ff;
   logic [15:0]          timeout_ff;

   // decoder state
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [31:0]          last_ff, last_in;
   logic [31:0]          white_ff, white_in;
   logic [CODE_BITS-1:0] bits_ff, bits_in;
   logic [32:0]          period_ff, period_in;
   logic                 err_ff, err_in;

   // divider
   logic [32:0]          dvsr_ff;
   logic [32:0]          rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DCNT_W-1:0]    dcnt_ff;
   logic [7:0]           code_hold_ff;
   logic [33:0]          trial;
   logic                 trial_ge;

   // result register
   logic [2:0]           out_status_ff, out_status_in;
   logic [7:0]           out_code_ff, out_code_in;
   logic [31:0]          out_vel_ff, out_vel_in;

   logic [CNT_W-1:0]     count_inc;
   logic                 count_full;
   logic [31:0]          dur;

   always_comb begin
      count_full     = (count_ff >= CNT_W'(END_COUNT));
      count_inc      = count_ff + CNT_W'(1);
      dur            = req_time - last_ff;
      sts.div_needed = !err_ff && count_full && (period_ff != 33'd0);
      sts.div_last   = (dcnt_ff == '0);
      trial          = {rem_ff, quo_ff[DIV_W-1]};
      trial_ge       = (trial >= {1'b0, dvsr_ff});
   end

   always_comb begin
      count_in      = count_ff;
      last_in       = last_ff;
      white_in      = white_ff;
      bits_in       = bits_ff;
      period_in     = period_ff;
      err_in        = err_ff;
      out_status_in = ST_IN_PROGRESS;
      out_code_in   = 8'd0;
      out_vel_in    = 32'd0;

      if (cmd.edge_go && !count_full) begin
         count_in = count_inc;
         if (req_pin != count_inc[0]) begin
            count_in = '0;
            err_in   = 1'b1;
         end else if (count_inc == CNT_W'(1)) begin
            last_in = req_time;
         end else if (count_inc < CNT_W'(END_COUNT)) begin
            if (req_pin) begin
               bits_in   = {bits_ff[CODE_BITS-2:0], (white_ff > dur)};
               period_in = {1'b0, white_ff} + {1'b0, dur};
            end else begin
               white_in = dur;
            end
            last_in = req_time;
         end
      end

      if (cmd.poll_go) begin
         priority if (err_ff) begin
            count_in      = '0;
            err_in        = 1'b0;
            out_status_in = ST_PHASE_ERROR;
         end else if (count_full) begin
            count_in      = '0;
            out_status_in = ST_SUCCESS;
            out_code_in   = 8'(bits_ff);
            out_vel_in    = '1;
         end else if (count_ff == '0) begin
            out_status_in = ST_NO_CODE;
         end else if (dur > {16'd0, timeout_ff}) begin
            count_in      = '0;
            out_status_in = ST_TIMEOUT;
         end else begin
            out_status_in = ST_IN_PROGRESS;
         end
      end

      if (cmd.load_div) begin
         out_status_in = ST_SUCCESS;
         out_code_in   = code_hold_ff;
         out_vel_in    = quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bls_ff     <= 32'd0;
         timeout_ff <= 16'hFFFF;
         count_ff   <= '0;
         last_ff    <= 32'd0;
         white_ff   <= 32'd0;
         bits_ff    <= '0;
         period_ff  <= 33'd0;
         err_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_BIT_LENGTH: bls_ff     <= csr_wdata;
               CSR_TIMEOUT:    timeout_ff <= csr_wdata[15:0];
               default:        ;
            endcase
         end
         count_ff  <= count_in;
         last_ff   <= last_in;
         white_ff  <= white_in;
         bits_ff   <= bits_in;
         period_ff <= period_in;
         err_ff    <= err_in;
      end
   end

   // restoring divider, one quotient bit per cycle; quo_ff starts as dividend
   always_ff @(posedge clock) begin
      if (cmd.poll_go && sts.div_needed) begin
         dvsr_ff      <= period_ff;
         rem_ff       <= 33'd0;
         quo_ff       <= bls_ff;
         dcnt_ff      <= DCNT_W'(DIV_W - 1);
         code_hold_ff <= 8'(bits_ff);
      end else if (cmd.div_step) begin
         rem_ff  <= trial_ge ? 33'(trial - {1'b0, dvsr_ff}) : trial[32:0];
         quo_ff  <= {quo_ff[DIV_W-2:0], trial_ge};
         dcnt_ff <= dcnt_ff - DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.poll_go && !sts.div_needed) || cmd.load_div) begin
         out_status_ff <= out_status_in;
         out_code_ff   <= out_code_in;
         out_vel_ff    <= out_vel_in;
      end
   end

   assign rsp_status   = out_status_ff;
   assign rsp_code     = out_code_ff;
   assign rsp_velocity = out_vel_ff;

endmodule

[bench/ebd_poll_checker.sv]
// ----------------------------------------------------------------------------
// ebd_poll_checker
// Watches the request, result and register ports of the barcode decoder,
// keeps its own copy of the decoder state, predicts the report of every
// accepted poll and compares each result transfer against it, field by field.
// ----------------------------------------------------------------------------
module ebd_poll_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        req_tuser,   // [0] operation
   input  logic [39:0] req_tdata,   // [0] pin_level, [32:1] time_us, [39:33] zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic [39:0] rsp_tdata,   // [7:0] code_value, [39:8] velocity
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);
   import ebd_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  code;
      logic [31:0] speed;
   } poll_report_type;

   poll_report_type poll_reports_q[$];

   // register copies
   logic [31:0] bit_len;
   logic [15:0] tmo_limit;

   // decoder copy
   logic [CNT_W-1:0]     edge_cnt;
   logic [31:0]          last_stamp;
   logic [31:0]          white_len;
   logic [CODE_BITS-1:0] code_bits;
   logic [32:0]          bit_period;
   logic                 err_latched;

   task automatic apply_sensor_edge(input logic pin, input logic [31:0] stamp);
      logic [31:0] gap;
      if (edge_cnt >= END_COUNT) return;
      edge_cnt = edge_cnt + 1'b1;
      if (pin != edge_cnt[0]) begin
         edge_cnt    = '0;
         err_latched = 1'b1;
         return;
      end
      if (edge_cnt == 1) begin
         last_stamp = stamp;
      end else if (edge_cnt < END_COUNT) begin
         gap = stamp - last_stamp;
         if (pin) begin
            code_bits  = {code_bits[CODE_BITS-2:0], (white_len > gap)};
            bit_period = {1'b0, white_len} + {1'b0, gap};
         end else begin
            white_len = gap;
         end
         last_stamp = stamp;
      end
   endtask

   function automatic poll_report_type predict_poll(input logic [31:0] stamp);
      poll_report_type  rep;
      longint unsigned  quot;
      logic [31:0]      since;
      rep   = '0;
      since = stamp - last_stamp;
      if (err_latched) begin
         edge_cnt    = '0;
         err_latched = 1'b0;
         rep.status  = ST_PHASE_ERROR;
      end else if (edge_cnt >= END_COUNT) begin
         rep.status = ST_SUCCESS;
         rep.code   = code_bits;
         if (bit_period == '0) begin
            rep.speed = '1;
         end else begin
            quot      = {32'd0, bit_len} / {31'd0, bit_period};
            rep.speed = quot[31:0];
         end
         edge_cnt = '0;
      end else if (edge_cnt == 0) begin
         rep.status = ST_NO_CODE;
      end else if (since > {16'd0, tmo_limit}) begin
         edge_cnt   = '0;
         rep.status = ST_TIMEOUT;
      end else begin
         rep.status = ST_IN_PROGRESS;
      end
      return rep;
   endfunction

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      poll_report_type want;
      if (reset) begin
         poll_reports_q.delete();
         bit_len     = '0;
         tmo_limit   = 16'hFFFF;
         edge_cnt    = '0;
         last_stamp  = '0;
         white_len   = '0;
         code_bits   = '0;
         bit_period  = '0;
         err_latched = 1'b0;
      end else begin
         // a result leaving now belongs to a poll taken at an earlier edge
         if (rsp_tvalid && rsp_tready) begin
            if (poll_reports_q.size() == 0) begin
               $display("%0t: result expected none actual status %0d code 0x%0h speed 0x%0h",
                        $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[39:8]);
               fail_count++;
            end else begin
               want = poll_reports_q.pop_front();
               if (rsp_tuser !== want.status)
                  report_field("status", 32'(want.status), 32'(rsp_tuser));
               if (rsp_tdata[7:0] !== want.code)
                  report_field("code_value", 32'(want.code), 32'(rsp_tdata[7:0]));
               if (rsp_tdata[39:8] !== want.speed)
                  report_field("velocity", want.speed, rsp_tdata[39:8]);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_POLL)
               poll_reports_q.push_back(predict_poll(req_tdata[32:1]));
            else
               apply_sensor_edge(req_tdata[0], req_tdata[32:1]);
         end
         if (csr_we) begin
            if (csr_addr == CSR_BIT_LENGTH)
               bit_len = csr_wdata;
            else
               tmo_limit = csr_wdata[15:0];
         end
      end
      outstanding <= poll_reports_q.size();
   end

endmodule

[bench/tb_edge_timed_barcode_decoder_core.sv]
// ----------------------------------------------------------------------------
// tb_edge_timed_barcode_decoder_core
// Drives sensor edges and status polls into the barcode decoder and gives the
// verdict. A directed opening covers the corner cases; random frames follow,
// mostly well-formed with random bar widths, mixed with broken frames and
// noise, over several register settings. Checking lives in ebd_poll_checker.
// ----------------------------------------------------------------------------
module tb_edge_timed_barcode_decoder_core;
   import ebd_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int ITEM_TARGET  = 1500;
   localparam int PHASES       = 5;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser  = OP_EDGE;   // [0] operation
   logic [39:0] req_tdata  = '0;        // [0] pin_level, [32:1] time_us, [39:33] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;              // [2:0] status
   logic [39:0] rsp_tdata;              // [7:0] code_value, [39:8] velocity
   logic        csr_we     = 1'b0;
   logic        csr_addr   = CSR_BIT_LENGTH;
   logic [31:0] csr_wdata  = '0;

   int          fail_count;
   int          outstanding;
   int          cycle_count = 0;
   int          sent = 0;
   bit          calm = 1'b0;            // no idling on either side while set
   logic [31:0] tmo_now = 32'd65535;    // current timeout setting, for poll timing

   edge_timed_barcode_decoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ebd_poll_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("edge_timed_barcode_decoder_core: mismatch");
         $finish;
      end
   end

   // Stall the result side at random, except during the calm stretch.
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 19);
   end

   // Offer one request transfer and hold it until it is taken. Random idle
   // cycles go in front; valid stays high straight into the next transfer
   // when there are none.
   task automatic put_item(input logic op, input logic pin, input logic [31:0] stamp,
                           input bit counts);
      while (!calm && $urandom_range(0, 99) < 19) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, stamp, pin};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (counts) sent++;
   endtask

   // Drop valid, wait for every expected report, then let the divider and the
   // result register run dry before anything else happens.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Bar width: mostly ordinary, with zero, tiny and wrap-sized widths mixed in.
   function automatic logic [31:0] bar_gap();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return $urandom();
         2:       return $urandom_range(1, 3);
         default: return $urandom_range(10, 3000);
      endcase
   endfunction

   // Poll delay after the last timed edge, clustered around the timeout.
   function automatic logic [31:0] poll_delay();
      case ($urandom_range(0, 4))
         0:       return tmo_now;
         1:       return tmo_now + 1;
         2:       return $urandom_range(0, tmo_now * 2 + 2);
         3:       return $urandom();
         default: return 32'd0;
      endcase
   endfunction

   // One frame of n sensor transitions, levels alternating from white. A nonzero bad_at
   // flips the level on that edge; mid_poll drops a poll into the frame.
   task automatic run_frame(input int n, input int bad_at, input bit mid_poll);
      logic [31:0] stamp;
      logic [31:0] white;
      logic [31:0] gap;
      int          mid_k;
      stamp = $urandom();
      white = '0;
      mid_k = $urandom_range(1, n);
      for (int k = 1; k <= n; k++) begin
         if (k > 1) begin
            if (k[0] == 1'b0) begin
               white = bar_gap();
               gap   = white;
            end else begin
               // equal widths decide a zero bit
               gap = ($urandom_range(0, 5) == 0) ? white : bar_gap();
            end
            stamp = stamp + gap;
         end
         put_item(OP_EDGE, k[0] ^ (k == bad_at), stamp, 1'b1);
         if (mid_poll && k == mid_k)
            put_item(OP_POLL, 1'($urandom_range(0, 1)), stamp + poll_delay(), 1'b1);
      end
      // edges past the full count are ignored by the decoder
      if (n == END_COUNT && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2))
            put_item(OP_EDGE, 1'($urandom_range(0, 1)), $urandom(), 1'b0);
      put_item(OP_POLL, 1'($urandom_range(0, 1)), stamp + poll_delay(), 1'b1);
   endtask

   // Pick register values for a phase; the first two are the extremes.
   task automatic configure(input int phase);
      logic [31:0] len_val;
      case (phase)
         0: begin
            len_val = 32'hFFFF_FFFF;
            tmo_now = 32'd0;
         end
         1: begin
            len_val = 32'd0;
            tmo_now = 32'd65535;
         end
         3: begin
            len_val = $urandom_range(0, 5000);
            tmo_now = $urandom_range(0, 300);
         end
         default: begin
            len_val = $urandom();
            tmo_now = $urandom_range(0, 65535);
         end
      endcase
      write_reg(CSR_BIT_LENGTH, len_val);
      write_reg(CSR_TIMEOUT, tmo_now);
   endtask

   initial begin
      int pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed opening, reset register values ----
      // poll on an empty decoder
      put_item(OP_POLL, 1'b0, $urandom(), 1'b1);
      // black level on the first edge latches a phase error; the next edge
      // still gets processed and the poll reports the error first
      put_item(OP_EDGE, 1'b0, 32'h0000_1000, 1'b1);
      put_item(OP_EDGE, 1'b1, 32'h0000_2000, 1'b1);
      put_item(OP_POLL, 1'b1, 32'h0000_2001, 1'b1);
      // full frame with every edge at one stamp: zero period saturates the
      // velocity; one more edge at full count must be ignored
      for (int k = 1; k <= END_COUNT; k++)
         put_item(OP_EDGE, k[0], 32'hFFFF_FFFF, 1'b1);
      put_item(OP_EDGE, 1'b1, 32'h0000_0000, 1'b0);
      put_item(OP_POLL, 1'b0, 32'hFFFF_FFFF, 1'b1);
      // elapsed time across the stamp wrap: in progress, then timed out
      put_item(OP_EDGE, 1'b1, 32'hFFFF_FFF0, 1'b1);
      put_item(OP_POLL, 1'b0, 32'h0000_0005, 1'b1);
      put_item(OP_POLL, 1'b0, 32'h0001_0000, 1'b1);

      // ---- random phases, registers changed only while idle ----
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         configure(phase);
         calm = (phase == 2);
         while (sent < (phase + 1) * (ITEM_TARGET / PHASES) + 10) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               run_frame(END_COUNT, 0, pick < 8);
            end else if (pick < 70) begin
               run_frame($urandom_range(1, END_COUNT - 1), 0, 1'b0);
            end else if (pick < 82) begin
               run_frame(END_COUNT, $urandom_range(1, END_COUNT),
                         1'($urandom_range(0, 1)));
            end else begin
               repeat ($urandom_range(1, 4))
                  put_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom(), 1'b1);
            end
         end
      end
      calm = 1'b0;

      settle();
      if (fail_count == 0 && outstanding == 0) begin
         $display("edge_timed_barcode_decoder_core: match");
      end else begin
         $display("edge_timed_barcode_decoder_core: mismatch");
      end
      $finish;
   end

endmodule
